/* design/pps_pkg.sv */
// shared types and constants of the pedestal pulse splitter
package pps_pkg;

  localparam int SAMPLE_W    = 12;
  localparam int VALUE_W     = 13;
  localparam int INDEX_W     = 10;
  localparam int SUM_W       = 17;
  localparam int THR_W       = 12;

  localparam int PED_SAMPLES = 30;
  localparam int MAX_SAMPLES = 1024;
  localparam int MAX_INDEX   = MAX_SAMPLES - 1;

  localparam int RECIP_SHIFT = 21;
  localparam int RECIP       = (1 << RECIP_SHIFT) / PED_SAMPLES;
  localparam int RECIP_W     = 17;
  localparam int PROD_W      = SUM_W + RECIP_W;

  localparam int THR_RESET   = 10;
  localparam int PREV_RESET  = 20;
  localparam int PREV2_RESET = 10;

  typedef logic [SAMPLE_W-1:0]       sample_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [INDEX_W-1:0]        index_t;
  typedef logic [SUM_W-1:0]          sum_t;
  typedef logic [THR_W-1:0]          thr_t;

  typedef struct packed {
    sample_t quot;
    logic    rem_nz;
  } ped_t;

endpackage

/* design/pps_if.sv */
// stream and configuration interfaces of the pedestal pulse splitter
interface pps_sample_if;
  logic            valid;
  logic            ready;
  pps_pkg::sample_t sample;
  logic            last_sample;

  modport source(output valid, sample, last_sample, input ready);
  modport sink(input valid, sample, last_sample, output ready);
endinterface

interface pps_pulse_if;
  logic            valid;
  logic            ready;
  pps_pkg::value_t corrected_value;
  logic            new_pulse;
  pps_pkg::index_t sample_index;

  modport source(output valid, corrected_value, new_pulse, sample_index, input ready);
  modport sink(input valid, corrected_value, new_pulse, sample_index, output ready);
endinterface

interface pps_cfg_if;
  logic           valid;
  logic           ready;
  pps_pkg::thr_t  data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

/* design/pps_pedestal.sv */
// pedestal accumulator with quotient and remainder-nonzero flag by the pedestal length
module pps_pedestal (
  input  logic             clk,
  input  logic             acc,
  input  pps_pkg::index_t  idx,
  input  pps_pkg::sample_t sample,
  output pps_pkg::ped_t    ped
);

  pps_pkg::sum_t              sum;
  pps_pkg::sum_t              sum_d;
  logic [pps_pkg::PROD_W-1:0] prod;
  pps_pkg::sample_t           quot0;
  pps_pkg::sum_t              rem0;
  logic                       rem_ge;
  pps_pkg::ped_t              ped_next;

  always_ff @(posedge clk) begin
    if (acc) begin
      if (idx == '0) begin
        sum <= pps_pkg::SUM_W'(sample);
      end else if (idx < pps_pkg::INDEX_W'(pps_pkg::PED_SAMPLES)) begin
        sum <= sum + pps_pkg::SUM_W'(sample);
      end
    end
  end

  // reciprocal multiply, corrected by one step below
  always_ff @(posedge clk) begin
    prod  <= pps_pkg::PROD_W'(sum) * pps_pkg::PROD_W'(pps_pkg::RECIP);
    sum_d <= sum;
    ped   <= ped_next;
  end

  always_comb begin
    quot0  = prod[pps_pkg::RECIP_SHIFT +: pps_pkg::SAMPLE_W];
    rem0   = sum_d - pps_pkg::SUM_W'(pps_pkg::SUM_W'(quot0) *
             pps_pkg::SUM_W'(pps_pkg::PED_SAMPLES));
    rem_ge = rem0 >= pps_pkg::SUM_W'(pps_pkg::PED_SAMPLES);
    if (rem_ge) begin
      ped_next.quot   = quot0 + pps_pkg::SAMPLE_W'(1);
      ped_next.rem_nz = rem0 != pps_pkg::SUM_W'(pps_pkg::PED_SAMPLES);
    end else begin
      ped_next.quot   = quot0;
      ped_next.rem_nz = rem0 != '0;
    end
  end

endmodule

/* design/pedestal_pulse_splitter.sv */
// top level: pedestal subtraction and threshold pulse splitting
//
// channel   dir  modport  payload
// samples   in   sink     sample[11:0], last_sample
// pulses    out  source   corrected_value[12:0] signed, new_pulse, sample_index[9:0]
// cfg       in   sink     data[11:0] -> pulse_threshold
//
// one sample per cycle while no stalled result holds the flow; a sample beat lands in the
// input register and its result, if one is emitted, in the result register after it
// the pedestal quotient settles in the multiply and correct registers while the
// skipped sample passes
// rst is synchronous and resets count, pulse state, history, threshold and the valid flags
// a stalled result holds the input register; a new beat still enters when
// the result is taken in the same cycle
module pedestal_pulse_splitter (
  input logic         clk,
  input logic         rst,
  pps_sample_if.sink  samples,
  pps_pulse_if.source pulses,
  pps_cfg_if.sink     cfg
);

  pps_pkg::thr_t    threshold;
  pps_pkg::index_t  count;
  logic             in_acc;

  logic             s1_valid;
  pps_pkg::sample_t s1_sample;
  pps_pkg::index_t  s1_idx;
  logic             s1_last;

  pps_pkg::ped_t    ped;

  logic             in_pulse;
  pps_pkg::value_t  prev;
  pps_pkg::value_t  prev2;

  logic             out_valid;
  pps_pkg::value_t  out_value;
  logic             out_new;
  pps_pkg::index_t  out_index;

  logic             out_free;
  logic             fire;
  logic             active;
  pps_pkg::value_t  diff;
  logic             diff_pos;
  pps_pkg::value_t  value;
  pps_pkg::value_t  thr_s;
  logic             emit;
  logic             fresh;
  logic             in_pulse_next;

  assign cfg.ready     = 1'b1;
  assign out_free      = !out_valid || pulses.ready;
  assign fire          = s1_valid && out_free;
  assign samples.ready = !s1_valid || out_free;
  assign in_acc        = samples.valid && samples.ready;

  assign pulses.valid           = out_valid;
  assign pulses.corrected_value = out_value;
  assign pulses.new_pulse       = out_new;
  assign pulses.sample_index    = out_index;

  pps_pedestal u_pedestal (
    .clk    (clk),
    .acc    (in_acc),
    .idx    (count),
    .sample (samples.sample),
    .ped    (ped)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= pps_pkg::THR_W'(pps_pkg::THR_RESET);
    end else if (cfg.valid && cfg.ready) begin
      threshold <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_acc) begin
      if (samples.last_sample) begin
        count <= '0;
      end else if (count < pps_pkg::INDEX_W'(pps_pkg::MAX_INDEX)) begin
        count <= count + pps_pkg::INDEX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample <= samples.sample;
      s1_idx    <= count;
      s1_last   <= samples.last_sample;
    end
  end

  // trunc((30*s - sum)/30) from sum = 30*quot + rem
  always_comb begin
    active   = s1_idx > pps_pkg::INDEX_W'(pps_pkg::PED_SAMPLES);
    diff     = $signed({1'b0, s1_sample}) - $signed({1'b0, ped.quot});
    diff_pos = !diff[pps_pkg::VALUE_W-1] && (diff != '0);
    value    = (ped.rem_nz && diff_pos) ? diff - pps_pkg::VALUE_W'(1) : diff;
    thr_s    = $signed({1'b0, threshold});

    emit          = 1'b0;
    fresh         = 1'b0;
    in_pulse_next = in_pulse;
    if (!in_pulse) begin
      if (value > thr_s) begin
        in_pulse_next = 1'b1;
        emit          = 1'b1;
        fresh         = 1'b1;
      end
    end else if (value < thr_s) begin
      in_pulse_next = 1'b0;
    end else if (prev2 < prev || value <= prev) begin
      emit = 1'b1;
    end else begin
      emit  = 1'b1;
      fresh = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_pulse <= 1'b0;
      prev     <= pps_pkg::VALUE_W'(pps_pkg::PREV_RESET);
      prev2    <= pps_pkg::VALUE_W'(pps_pkg::PREV2_RESET);
    end else if (fire) begin
      if (s1_last) begin
        in_pulse <= 1'b0;
        prev     <= pps_pkg::VALUE_W'(pps_pkg::PREV_RESET);
        prev2    <= pps_pkg::VALUE_W'(pps_pkg::PREV2_RESET);
      end else if (active) begin
        in_pulse <= in_pulse_next;
        prev     <= value;
        prev2    <= prev;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && active && emit) begin
      out_valid <= 1'b1;
    end else if (pulses.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && active && emit) begin
      out_value <= value;
      out_new   <= fresh;
      out_index <= s1_idx;
    end
  end

endmodule

/* design/pps_checker.sv */
// port-level assertions for the pedestal pulse splitter and their bind
module pps_checker (
  input logic            clk,
  input logic            rst,
  input logic            out_valid,
  input logic            out_ready,
  input pps_pkg::value_t out_value,
  input logic            out_new,
  input pps_pkg::index_t out_index
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) &&
      $stable(out_new) && $stable(out_index))
    else $error("pulse beat dropped or changed while stalled");

  a_nonneg: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !out_value[pps_pkg::VALUE_W-1])
    else $error("pulse beat carries a value below zero");

  a_index: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_index > pps_pkg::INDEX_W'(pps_pkg::PED_SAMPLES))
    else $error("pulse beat from the pedestal window");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("pulse beat right after reset");

endmodule

bind pedestal_pulse_splitter pps_checker u_pps_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (pulses.valid),
  .out_ready (pulses.ready),
  .out_value (pulses.corrected_value),
  .out_new   (pulses.new_pulse),
  .out_index (pulses.sample_index)
);

/* tb/pedestal_pulse_splitter_tb.sv */
// testbench of the pedestal pulse splitter: directed and random traces checked against a predictor
module pedestal_pulse_splitter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    pps_pkg::value_t value;
    logic            fresh;
    pps_pkg::index_t index;
  } pulse_rec_t;

  class pulse_scoreboard;
    pps_pkg::thr_t threshold;
    int unsigned   count;
    int            ped_sum;
    bit            in_pulse;
    int            prev_val;
    int            prev2_val;
    pulse_rec_t    pulses_due[$];
    int            errors;

    function new();
      threshold = pps_pkg::THR_W'(pps_pkg::THR_RESET);
      errors = 0;
      clear_trace();
    endfunction

    function void clear_trace();
      count = 0;
      ped_sum = 0;
      in_pulse = 0;
      prev_val = pps_pkg::PREV_RESET;
      prev2_val = pps_pkg::PREV2_RESET;
    endfunction

    function void note_sample(pps_pkg::sample_t s, logic last);
      int         v;
      int         thr;
      bit         emit;
      bit         fresh;
      pulse_rec_t rec;
      emit = 0;
      fresh = 0;
      if (count < pps_pkg::PED_SAMPLES) begin
        ped_sum += int'(s);
      end else if (count > pps_pkg::PED_SAMPLES) begin
        v = (pps_pkg::PED_SAMPLES * int'(s) - ped_sum) / pps_pkg::PED_SAMPLES;
        thr = int'(threshold);
        if (!in_pulse) begin
          if (v > thr) begin
            in_pulse = 1;
            emit = 1;
            fresh = 1;
          end
        end else if (v < thr) begin
          in_pulse = 0;
        end else if (prev2_val < prev_val || v <= prev_val) begin
          emit = 1;
        end else begin
          emit = 1;
          fresh = 1;
        end
        prev2_val = prev_val;
        prev_val = v;
        if (emit) begin
          rec.value = pps_pkg::value_t'(v);
          rec.fresh = fresh;
          rec.index = pps_pkg::index_t'(count);
          pulses_due = {pulses_due, rec};
        end
      end
      if (count < pps_pkg::MAX_INDEX) count++;
      if (last) clear_trace();
    endfunction

    function void check_pulse(pps_pkg::value_t v, logic np, pps_pkg::index_t idx);
      pulse_rec_t want;
      if (pulses_due.size() == 0) begin
        $error("unexpected beat: corrected_value %0d new_pulse %0b sample_index %0d",
               v, np, idx);
        errors++;
        return;
      end
      want = pulses_due.pop_front();
      if (v !== want.value) begin
        $error("corrected_value: expected %0d, actual %0d", want.value, v);
        errors++;
      end
      if (np !== want.fresh) begin
        $error("new_pulse: expected %0b, actual %0b", want.fresh, np);
        errors++;
      end
      if (idx !== want.index) begin
        $error("sample_index: expected %0d, actual %0d", want.index, idx);
        errors++;
      end
    endfunction

    function int pending();
      return pulses_due.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  pps_sample_if samples_if();
  pps_pulse_if  pulses_if();
  pps_cfg_if    cfg_if();

  pedestal_pulse_splitter dut (
    .clk(clk),
    .rst(rst),
    .samples(samples_if),
    .pulses(pulses_if),
    .cfg(cfg_if)
  );

  pulse_scoreboard sb = new();

  bit tx_burst = 0;
  int samples_sent = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("pedestal_pulse_splitter_tb: done, errors");
    $finish;
  end

  // result side: random stalls, plus two long hold-offs
  initial begin
    int rx_gap;
    int long_hold;
    int results_seen;
    bit rx_burst;
    rx_gap = 0;
    long_hold = 0;
    results_seen = 0;
    rx_burst = 0;
    pulses_if.ready <= 0;
    forever begin
      @(posedge clk);
      if (pulses_if.valid && pulses_if.ready) begin
        sb.check_pulse(pulses_if.corrected_value, pulses_if.new_pulse,
                       pulses_if.sample_index);
        results_seen++;
        if (results_seen == 25 || results_seen == 120) long_hold = 300;
        if ($urandom_range(0, 49) == 0) rx_burst = !rx_burst;
        rx_gap = rx_burst ? 0 : $urandom_range(0, 7);
      end
      if (long_hold > 0) begin
        long_hold--;
        pulses_if.ready <= 0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        pulses_if.ready <= 0;
      end else begin
        pulses_if.ready <= 1;
      end
    end
  end

  function automatic pps_pkg::sample_t clamp_sample(int x);
    if (x < 0) return '0;
    if (x > 4095) return pps_pkg::sample_t'(4095);
    return pps_pkg::sample_t'(x);
  endfunction

  task automatic send_beat(input pps_pkg::sample_t s, input logic last);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      samples_if.valid <= 0;
      @(posedge clk);
    end
    samples_if.valid <= 1;
    samples_if.sample <= s;
    samples_if.last_sample <= last;
    do @(posedge clk); while (!(samples_if.valid && samples_if.ready));
    sb.note_sample(s, last);
    samples_sent++;
  endtask

  task automatic send_flat(input pps_pkg::sample_t s, input int n);
    repeat (n) send_beat(s, 1'b0);
  endtask

  task automatic drain();
    samples_if.valid <= 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_threshold(input pps_pkg::thr_t thr);
    drain();
    cfg_if.valid <= 1;
    cfg_if.data <= thr;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    cfg_if.valid <= 0;
    sb.threshold = thr;
  endtask

  // pedestal near a base level, then pulses that rise, fall and dip near threshold
  task automatic run_shaped_trace(input int len);
    int base;
    int lvl;
    int target;
    int hold;
    int thr;
    int i;
    base = $urandom_range(0, 3000);
    lvl = 0;
    hold = 0;
    target = 0;
    thr = int'(sb.threshold);
    for (i = 0; i < len; i++) begin
      if (i > pps_pkg::PED_SAMPLES) begin
        if (hold == 0) begin
          case ($urandom_range(0, 3))
            0: target = 0;
            1: target = thr + $urandom_range(0, 6) - 3;
            2: target = thr + $urandom_range(0, 200);
            default: target = $urandom_range(0, 4095 - base);
          endcase
          hold = $urandom_range(1, 6);
        end
        hold--;
        lvl = lvl + (target - lvl) / 2 + int'($urandom_range(0, 4)) - 2;
      end
      send_beat(clamp_sample(base + lvl + $urandom_range(0, 6) - 3), i == len - 1);
    end
  endtask

  task automatic run_noise_trace(input int len);
    int i;
    for (i = 0; i < len; i++) begin
      send_beat(pps_pkg::sample_t'($urandom_range(0, 4095)), i == len - 1);
    end
  endtask

  task automatic run_random_traces(input int quota);
    int stop_at;
    int pick;
    stop_at = samples_sent + quota;
    while (samples_sent < stop_at) begin
      tx_burst = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 19);
      if (pick < 3) run_shaped_trace($urandom_range(1, 31));
      else if (pick < 6) run_noise_trace($urandom_range(31, 60));
      else run_shaped_trace($urandom_range(32, 90));
    end
    tx_burst = 0;
  endtask

  initial begin
    rst <= 1;
    samples_if.valid <= 0;
    samples_if.sample <= '0;
    samples_if.last_sample <= 0;
    cfg_if.valid <= 0;
    cfg_if.data <= '0;
    repeat (9) @(posedge clk);
    rst <= 0;

    // one-sample trace, then a trace that ends on the skipped sample
    send_beat(pps_pkg::sample_t'(4095), 1'b1);
    send_flat(pps_pkg::sample_t'(4095), 30);
    send_beat('0, 1'b1);

    // zero pedestal: full-scale pulse, flat, dip and a new pulse at the minimum
    send_flat('0, 31);
    send_beat(pps_pkg::sample_t'(4095), 1'b0);
    send_beat(pps_pkg::sample_t'(4095), 1'b0);
    send_beat(pps_pkg::sample_t'(100), 1'b0);
    send_beat(pps_pkg::sample_t'(4095), 1'b0);
    send_beat(pps_pkg::sample_t'(4095), 1'b1);

    // pedestal sum of one: truncation toward zero around the threshold
    send_flat('0, 29);
    send_beat(pps_pkg::sample_t'(1), 1'b0);
    send_beat('0, 1'b0);
    send_beat('0, 1'b0);
    send_beat(pps_pkg::sample_t'(11), 1'b0);
    send_beat(pps_pkg::sample_t'(12), 1'b0);
    send_beat(pps_pkg::sample_t'(11), 1'b0);
    send_beat(pps_pkg::sample_t'(10), 1'b0);
    send_beat(pps_pkg::sample_t'(13), 1'b1);

    // full-scale pedestal: corrected values go negative
    send_flat(pps_pkg::sample_t'(4095), 31);
    send_beat('0, 1'b0);
    send_beat(pps_pkg::sample_t'(4095), 1'b1);

    write_threshold(pps_pkg::thr_t'(0));
    run_random_traces(80);
    write_threshold(pps_pkg::thr_t'(4095));
    run_random_traces(60);
    write_threshold(pps_pkg::thr_t'($urandom_range(0, 40)));
    run_random_traces(80);
    write_threshold(pps_pkg::thr_t'(10));
    run_random_traces(80);
    write_threshold(pps_pkg::thr_t'($urandom_range(0, 4095)));
    run_random_traces(70);
    write_threshold(pps_pkg::thr_t'($urandom_range(0, 300)));
    run_random_traces(80);

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("pedestal_pulse_splitter_tb: done, clean");
    end else begin
      $display("pedestal_pulse_splitter_tb: done, errors");
    end
    $finish;
  end

endmodule
